// ===== rtl/ogg_page_deframer_top_macros.svh =====
// assertion macros for the ogg page deframer
// expects aclk and aresetn in the scope of use
`ifndef OGG_PAGE_DEFRAMER_TOP_MACROS_SVH
`define OGG_PAGE_DEFRAMER_TOP_MACROS_SVH
// same-cycle implication
`define OPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("opd assertion failed");
// next-cycle implication
`define OPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("opd assertion failed");
`endif

// ===== rtl/opd_pkg.sv =====
// types, codes and constants of the ogg page deframer
// no dependencies
package opd_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 65536;
    localparam int MAX_SEGMENTS_DEF     = 255;

    localparam logic [7:0] LACE_CONT = 8'd255;
    localparam logic [7:0] CAP_O     = 8'h4F;
    localparam logic [7:0] CAP_G     = 8'h67;
    localparam logic [7:0] CAP_S     = 8'h53;

    localparam logic [4:0] HDR_VERSION    = 5'd4;
    localparam logic [4:0] HDR_FLAGS      = 5'd5;
    localparam logic [4:0] HDR_GRANULE_LO = 5'd6;
    localparam logic [4:0] HDR_GRANULE_HI = 5'd13;
    localparam logic [4:0] HDR_SERIAL_LO  = 5'd14;
    localparam logic [4:0] HDR_SERIAL_HI  = 5'd17;
    localparam logic [4:0] HDR_SEQ_LO     = 5'd18;
    localparam logic [4:0] HDR_SEQ_HI     = 5'd21;
    localparam logic [4:0] HDR_CKSUM_LO   = 5'd22;
    localparam logic [4:0] HDR_CKSUM_HI   = 5'd25;
    localparam logic [4:0] HDR_CAPTURED   = 5'd4;

    typedef enum logic [1:0] {
        KIND_PAYLOAD,
        KIND_HEADER,
        KIND_ERROR
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_CAPTURE,
        ERR_TOO_LARGE
    } err_t;

    // one compacted lacing entry: nonzero lacing value and zero values after it
    typedef struct packed {
        logic [7:0] lac;
        logic [7:0] zeros;
    } entry_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [7:0]  packets_ended;
        logic [63:0] granule_pos;
        logic [31:0] serial_number;
        logic [31:0] sequence_number;
        logic [31:0] page_checksum;
        logic [7:0]  header_flags;
        logic [7:0]  stream_version;
        logic [7:0]  segment_count;
        err_t        error_code;
    } res_t;

    function automatic logic [7:0] capture_byte(input logic [1:0] k);
        logic [7:0] c;
        case (k)
            2'd0:    c = CAP_O;
            2'd1:    c = CAP_G;
            2'd2:    c = CAP_G;
            default: c = CAP_S;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/ogg_page_deframer_top.sv =====
// ogg page deframer: one input byte per item, one result register plus skid item
// results are registered in the output register or, while items wait, in the skid item
// throughput: one byte per clock; s_ready drops only while output and skid both hold items
// the next lacing entry is prefetched from the lacing ram ahead of use
// reset (synchronous, aresetn low) clears control state; the lacing ram is not cleared
// depends on opd_pkg, opd_ram and ogg_page_deframer_top_macros.svh
`include "ogg_page_deframer_top_macros.svh"
module ogg_page_deframer_top
    import opd_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
    parameter int MAX_SEGMENTS     = MAX_SEGMENTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_data_byte,
    output logic [7:0]  m_packets_ended,
    output logic [63:0] m_granule_pos,
    output logic [31:0] m_serial_number,
    output logic [31:0] m_sequence_number,
    output logic [31:0] m_page_checksum,
    output logic [7:0]  m_header_flags,
    output logic [7:0]  m_stream_version,
    output logic [7:0]  m_segment_count,
    output logic [1:0]  m_error_code
);

    localparam int SEG_W     = $clog2(MAX_SEGMENTS + 1);
    localparam int RAM_DEPTH = 1 << SEG_W;
    localparam int PL_W      = $clog2(MAX_PACKET_BYTES + 256);
    localparam logic [7:0]      SEG_LIMIT = 8'(MAX_SEGMENTS);
    localparam logic [PL_W-1:0] PL_LIMIT  = PL_W'(MAX_PACKET_BYTES);

    typedef enum logic [2:0] {
        PH_EXPECT,
        PH_RESYNC,
        PH_HEADER,
        PH_LACING,
        PH_PAYLOAD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  hi_reg, hi_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  flags_reg, flags_next;
    logic [63:0] granule_reg, granule_next;
    logic [31:0] serial_reg, serial_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] cksum_reg, cksum_next;
    logic [7:0]  segcnt_reg, segcnt_next;
    logic [7:0]  lead_reg, lead_next;
    logic [SEG_W-1:0] stored_reg, stored_next;
    logic [SEG_W-1:0] lac_cnt_reg, lac_cnt_next;
    logic [SEG_W-1:0] si_reg, si_next;
    logic [7:0]  bl_reg, bl_next;
    logic [PL_W-1:0] plen_reg, plen_next;
    entry_t      pend_reg, pend_next;
    entry_t      e0_reg, e0_next;
    entry_t      cur_reg, cur_next;
    entry_t      byp_reg;
    logic        byp_hit_reg, byp_hit_next;
    res_t        out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;

    res_t        res;
    logic        res_valid;
    logic        accept;
    logic        wr_en;
    logic [SEG_W-1:0] wr_addr;
    entry_t      wr_data;
    logic [SEG_W-1:0] rd_addr;
    logic [15:0] rd_data;
    entry_t      nxt;
    logic [SEG_W-1:0] si_inc;
    logic        pop;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;
    assign si_inc  = si_reg + SEG_W'(1);

    // entry after the current one: last entry lives in pend, else ram with bypass
    always_comb begin
        if (si_inc == stored_reg - SEG_W'(1)) begin
            nxt = pend_reg;
        end else if (byp_hit_reg) begin
            nxt = byp_reg;
        end else begin
            nxt = entry_t'(rd_data);
        end
    end

    always_comb begin
        logic [PL_W-1:0] sum;
        logic [8:0]      ends;
        logic [1:0]      k;
        phase_next   = phase_reg;
        hi_next      = hi_reg;
        version_next = version_reg;
        flags_next   = flags_reg;
        granule_next = granule_reg;
        serial_next  = serial_reg;
        seq_next     = seq_reg;
        cksum_next   = cksum_reg;
        segcnt_next  = segcnt_reg;
        lead_next    = lead_reg;
        stored_next  = stored_reg;
        lac_cnt_next = lac_cnt_reg;
        si_next      = si_reg;
        bl_next      = bl_reg;
        plen_next    = plen_reg;
        pend_next    = pend_reg;
        cur_next     = cur_reg;
        res          = '0;
        res_valid    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = stored_reg - SEG_W'(1);
        wr_data      = pend_reg;
        sum          = plen_reg + PL_W'(s_in_byte);
        ends         = '0;
        k            = hi_reg[1:0];
        if (accept) begin
            case (phase_reg)
                PH_EXPECT, PH_RESYNC: begin
                    if (s_in_byte == capture_byte(k)) begin
                        hi_next = {3'd0, k} + 5'd1;
                        if (hi_next == HDR_CAPTURED) begin
                            phase_next = PH_HEADER;
                        end
                    end else begin
                        hi_next = (s_in_byte == CAP_O) ? 5'd1 : 5'd0;
                        if (phase_reg == PH_EXPECT) begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_CAPTURE;
                            phase_next     = PH_RESYNC;
                            plen_next      = '0;
                        end
                    end
                end
                PH_HEADER: begin
                    hi_next = hi_reg + 5'd1;
                    if (hi_reg == HDR_VERSION) begin
                        version_next = s_in_byte;
                    end else if (hi_reg == HDR_FLAGS) begin
                        flags_next = s_in_byte;
                    end else if (hi_reg >= HDR_GRANULE_LO && hi_reg <= HDR_GRANULE_HI) begin
                        granule_next = {s_in_byte, granule_reg[63:8]};
                    end else if (hi_reg >= HDR_SERIAL_LO && hi_reg <= HDR_SERIAL_HI) begin
                        serial_next = {s_in_byte, serial_reg[31:8]};
                    end else if (hi_reg >= HDR_SEQ_LO && hi_reg <= HDR_SEQ_HI) begin
                        seq_next = {s_in_byte, seq_reg[31:8]};
                    end else if (hi_reg >= HDR_CKSUM_LO && hi_reg <= HDR_CKSUM_HI) begin
                        cksum_next = {s_in_byte, cksum_reg[31:8]};
                    end else begin
                        segcnt_next  = s_in_byte;
                        lead_next    = '0;
                        stored_next  = '0;
                        lac_cnt_next = '0;
                        si_next      = '0;
                        hi_next      = hi_reg;
                        if (s_in_byte > SEG_LIMIT) begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_TOO_LARGE;
                            phase_next     = PH_RESYNC;
                            hi_next        = '0;
                            plen_next      = '0;
                        end else if (s_in_byte == 8'd0) begin
                            res_valid  = 1'b1;
                            res.kind   = KIND_HEADER;
                            phase_next = PH_EXPECT;
                            hi_next    = '0;
                        end else begin
                            phase_next = PH_LACING;
                        end
                    end
                end
                PH_LACING: begin
                    if (sum > PL_LIMIT) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_TOO_LARGE;
                        phase_next     = PH_RESYNC;
                        hi_next        = '0;
                        plen_next      = '0;
                    end else begin
                        plen_next = (s_in_byte != LACE_CONT) ? '0 : sum;
                        if (s_in_byte == 8'd0) begin
                            if (stored_reg == '0) begin
                                lead_next = lead_reg + 8'd1;
                            end else begin
                                pend_next.zeros = pend_reg.zeros + 8'd1;
                            end
                        end else begin
                            wr_en           = (stored_reg != '0);
                            pend_next.lac   = s_in_byte;
                            pend_next.zeros = '0;
                            stored_next     = stored_reg + SEG_W'(1);
                        end
                        lac_cnt_next = lac_cnt_reg + SEG_W'(1);
                        if (8'(lac_cnt_next) >= segcnt_reg) begin
                            res_valid     = 1'b1;
                            res.kind      = KIND_HEADER;
                            if (stored_next == '0) begin
                                phase_next = PH_EXPECT;
                                hi_next    = '0;
                            end else begin
                                phase_next = PH_PAYLOAD;
                                si_next    = '0;
                                cur_next   = (stored_next == SEG_W'(1)) ? pend_next : e0_next;
                                bl_next    = cur_next.lac;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    res_valid     = 1'b1;
                    res.kind      = KIND_PAYLOAD;
                    res.data_byte = s_in_byte;
                    if (bl_reg > 8'd1) begin
                        bl_next = bl_reg - 8'd1;
                    end else begin
                        bl_next = '0;
                        ends    = {8'd0, cur_reg.lac != LACE_CONT} + {1'b0, cur_reg.zeros};
                        res.packets_ended = ends[7:0];
                        if (si_inc >= stored_reg) begin
                            phase_next = PH_EXPECT;
                            hi_next    = '0;
                            si_next    = '0;
                        end else begin
                            si_next  = si_inc;
                            cur_next = nxt;
                            bl_next  = nxt.lac;
                        end
                    end
                end
                default: begin
                    phase_next = PH_EXPECT;
                    hi_next    = '0;
                end
            endcase
        end
        if (res.kind == KIND_HEADER) begin
            res.packets_ended   = lead_next;
            res.granule_pos     = granule_reg;
            res.serial_number   = serial_reg;
            res.sequence_number = seq_reg;
            res.page_checksum   = cksum_reg;
            res.header_flags    = flags_reg;
            res.stream_version  = version_reg;
            res.segment_count   = segcnt_next;
        end
    end

    assign e0_next      = (wr_en && wr_addr == '0) ? wr_data : e0_reg;
    assign rd_addr      = si_next + SEG_W'(1);
    assign byp_hit_next = wr_en && (wr_addr == rd_addr);

    opd_ram #(
        .WIDTH(16),
        .DEPTH(RAM_DEPTH)
    ) u_lacing_ram (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(wr_addr),
        .wdata(wr_data),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    always_ff @(posedge aclk) begin
        version_reg <= version_next;
        flags_reg   <= flags_next;
        granule_reg <= granule_next;
        serial_reg  <= serial_next;
        seq_reg     <= seq_next;
        cksum_reg   <= cksum_next;
        segcnt_reg  <= segcnt_next;
        pend_reg    <= pend_next;
        e0_reg      <= e0_next;
        cur_reg     <= cur_next;
        byp_reg     <= wr_data;
        if (!aresetn) begin
            phase_reg      <= PH_EXPECT;
            hi_reg         <= '0;
            lead_reg       <= '0;
            stored_reg     <= '0;
            lac_cnt_reg    <= '0;
            si_reg         <= '0;
            bl_reg         <= '0;
            plen_reg       <= '0;
            byp_hit_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            hi_reg      <= hi_next;
            lead_reg    <= lead_next;
            stored_reg  <= stored_next;
            lac_cnt_reg <= lac_cnt_next;
            si_reg      <= si_next;
            bl_reg      <= bl_next;
            plen_reg    <= plen_next;
            byp_hit_reg <= byp_hit_next;
            if (!out_valid_reg || pop) begin
                if (skid_valid_reg) begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_reg       <= res;
                    skid_valid_reg <= res_valid;
                end else begin
                    out_reg        <= res;
                    out_valid_reg  <= res_valid;
                end
            end else if (res_valid) begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_kind            = out_reg.kind;
    assign m_data_byte       = out_reg.data_byte;
    assign m_packets_ended   = out_reg.packets_ended;
    assign m_granule_pos     = out_reg.granule_pos;
    assign m_serial_number   = out_reg.serial_number;
    assign m_sequence_number = out_reg.sequence_number;
    assign m_page_checksum   = out_reg.page_checksum;
    assign m_header_flags    = out_reg.header_flags;
    assign m_stream_version  = out_reg.stream_version;
    assign m_segment_count   = out_reg.segment_count;
    assign m_error_code      = out_reg.error_code;

    `OPD_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `OPD_ASSERT_NOW(a_payload_entries, phase_reg == PH_PAYLOAD, stored_reg != '0 && si_reg < stored_reg && bl_reg != '0)
    `OPD_ASSERT_NEXT(a_bypass_once, byp_hit_reg, !byp_hit_reg)
    `OPD_ASSERT_NOW(a_error_has_code, m_valid && m_kind == KIND_ERROR, m_error_code != ERR_NONE)

endmodule

// ===== rtl/opd_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module opd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
